FILE: rtl/core/stq_pkg.sv
package stq_pkg;

	localparam int NUM_TIMERS  = 16;
	localparam int MAX_RESULTS = 16;
	localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int CNT_W = $clog2(NUM_TIMERS + 1);
	localparam int RES_W = $clog2(MAX_RESULTS + 1);
	localparam int TW    = 31;
	localparam logic [TW-1:0] DEADLINE_MAX = 31'h7FFF_FFFE;
	localparam logic [TW-1:0] ID_MAX       = 31'h7FFF_FFFF;
	localparam logic [TW-1:0] ID_FIRST     = 31'd1;

	typedef enum logic [1:0] {
		ACT_ADD     = 2'd0,
		ACT_REMOVE  = 2'd1,
		ACT_TRIGGER = 2'd2,
		ACT_QUERY   = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		KIND_ADDED      = 3'd0,
		KIND_FULL       = 3'd1,
		KIND_REMOVED    = 3'd2,
		KIND_NOT_FOUND  = 3'd3,
		KIND_FIRED      = 3'd4,
		KIND_NONE_FIRED = 3'd5,
		KIND_NEXT       = 3'd6
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_INS_SCAN,
		ST_DEL_SCAN,
		ST_TRG_SCAN,
		ST_TRG_EMIT,
		ST_FINISH,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic  start;
		logic  p_inc;
		logic  p_clr;
		logic  add_prep;
		logic  trg_take;
		logic  ins_at_p;
		logic  rm_at_p;
		logic  emit_fire;
		logic  out_direct;
		logic  out_final;
		kind_t rkind;
	} ctl_cmd_t;

	typedef struct packed {
		action_t act;
		logic    full;
		logic    p_end;
		logic    cur_lt;
		logic    cur_le_now;
		logic    cur_fired;
		logic    cur_match;
		logic    cur_per_nz;
		logic    tgt_ok;
		logic    out_free;
		logic    pend_v;
		logic    nres_max;
	} dp_stat_t;

	function automatic logic [TW-1:0] sat_add(input logic [TW-1:0] a, input logic [TW-1:0] b);
		logic [TW:0] s;
		s = {1'b0, a} + {1'b0, b};
		return (s > {1'b0, DEADLINE_MAX}) ? DEADLINE_MAX : s[TW-1:0];
	endfunction

endpackage

FILE: rtl/core/stq_ctrl.sv
module stq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  stq_pkg::dp_stat_t   stat,
	output stq_pkg::ctl_cmd_t   cmd
);

	stq_pkg::state_t state_q, state_d;
	stq_pkg::kind_t  resp_q, resp_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stq_pkg::ST_IDLE;
			resp_q  <= stq_pkg::KIND_ADDED;
		end else begin
			state_q <= state_d;
			resp_q  <= resp_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		resp_d    = resp_q;
		cmd       = '0;
		cmd.rkind = resp_q;
		req_stall = (state_q != stq_pkg::ST_IDLE);
		case (state_q)
			stq_pkg::ST_IDLE: begin
				if (req_valid) begin
					cmd.start = 1'b1;
					state_d   = stq_pkg::ST_DECODE;
				end
			end
			stq_pkg::ST_DECODE: begin
				case (stat.act)
					stq_pkg::ACT_ADD: begin
						if (stat.full) begin
							resp_d  = stq_pkg::KIND_FULL;
							state_d = stq_pkg::ST_RESP;
						end else begin
							cmd.add_prep = 1'b1;
							state_d      = stq_pkg::ST_INS_SCAN;
						end
					end
					stq_pkg::ACT_REMOVE: begin
						if (stat.tgt_ok) begin
							state_d = stq_pkg::ST_DEL_SCAN;
						end else begin
							resp_d  = stq_pkg::KIND_NOT_FOUND;
							state_d = stq_pkg::ST_RESP;
						end
					end
					stq_pkg::ACT_TRIGGER: begin
						state_d = stq_pkg::ST_TRG_SCAN;
					end
					default: begin
						resp_d  = stq_pkg::KIND_NEXT;
						state_d = stq_pkg::ST_RESP;
					end
				endcase
			end
			stq_pkg::ST_INS_SCAN: begin
				if (!stat.p_end && stat.cur_lt) begin
					cmd.p_inc = 1'b1;
				end else begin
					cmd.ins_at_p = 1'b1;
					if (stat.act == stq_pkg::ACT_ADD) begin
						resp_d  = stq_pkg::KIND_ADDED;
						state_d = stq_pkg::ST_RESP;
					end else begin
						state_d = stq_pkg::ST_TRG_EMIT;
					end
				end
			end
			stq_pkg::ST_DEL_SCAN: begin
				if (stat.p_end) begin
					resp_d  = stq_pkg::KIND_NOT_FOUND;
					state_d = stq_pkg::ST_RESP;
				end else if (stat.cur_match) begin
					cmd.rm_at_p = 1'b1;
					resp_d      = stq_pkg::KIND_REMOVED;
					state_d     = stq_pkg::ST_RESP;
				end else begin
					cmd.p_inc = 1'b1;
				end
			end
			stq_pkg::ST_TRG_SCAN: begin
				if (stat.nres_max || stat.p_end || !stat.cur_le_now) begin
					state_d = stq_pkg::ST_FINISH;
				end else if (stat.cur_fired) begin
					cmd.p_inc = 1'b1;
				end else begin
					cmd.trg_take = 1'b1;
					cmd.rm_at_p  = 1'b1;
					cmd.p_clr    = 1'b1;
					state_d = stat.cur_per_nz ? stq_pkg::ST_INS_SCAN : stq_pkg::ST_TRG_EMIT;
				end
			end
			stq_pkg::ST_TRG_EMIT: begin
				if (!stat.pend_v || stat.out_free) begin
					cmd.emit_fire = 1'b1;
					cmd.p_clr     = 1'b1;
					state_d       = stq_pkg::ST_TRG_SCAN;
				end
			end
			stq_pkg::ST_FINISH: begin
				if (stat.out_free) begin
					cmd.out_final = 1'b1;
					state_d       = stq_pkg::ST_IDLE;
				end
			end
			stq_pkg::ST_RESP: begin
				if (stat.out_free) begin
					cmd.out_direct = 1'b1;
					state_d        = stq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = stq_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

FILE: rtl/core/stq_dp.sv
module stq_dp (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [1:0]             action,
	input  logic [30:0]            now_time,
	input  logic [30:0]            start_delay,
	input  logic [30:0]            period,
	input  logic                   repeating,
	input  logic signed [31:0]     target_id,
	input  logic                   rsp_stall,
	output logic                   rsp_valid,
	output logic [2:0]             kind,
	output logic [30:0]            timer_id,
	output logic [30:0]            deadline,
	output logic [6:0]             live_timers,
	output logic                   last,
	input  stq_pkg::ctl_cmd_t      cmd,
	output stq_pkg::dp_stat_t      stat
);

	localparam int N  = stq_pkg::NUM_TIMERS;
	localparam int TW = stq_pkg::TW;
	localparam int CW = stq_pkg::CNT_W;
	localparam int IW = stq_pkg::IDX_W;

	stq_pkg::action_t       act_q;
	logic [TW-1:0]          now_q, delay_q, per_in_q;
	logic                   rep_q;
	logic signed [31:0]     tgt_q;

	logic [TW-1:0]          id_q [N];
	logic [TW-1:0]          dl_q [N];
	logic [TW-1:0]          pr_q [N];
	logic [N-1:0]           fired_q;
	logic [CW-1:0]          cnt_q;
	logic [TW-1:0]          next_id_q;
	logic [CW-1:0]          p_q;
	logic [TW-1:0]          key_q, ins_id_q, ins_per_q;
	logic                   ins_fired_q;
	logic [stq_pkg::RES_W-1:0] nres_q;
	logic                   pend_v_q;
	logic [TW-1:0]          pend_id_q;
	logic [CW-1:0]          pend_live_q;

	logic                   rsp_valid_q, last_q;
	stq_pkg::kind_t         kind_q;
	logic [TW-1:0]          tid_q, dlo_q;
	logic [CW-1:0]          live_q;

	logic [IW-1:0]          p_idx;
	logic                   out_free;
	logic [TW-1:0]          cur_id, cur_dl, cur_pr;
	logic [TW-1:0]          dir_id, dir_dl;

	assign p_idx    = (p_q < CW'(N)) ? p_q[IW-1:0] : '0;
	assign cur_id   = id_q[p_idx];
	assign cur_dl   = dl_q[p_idx];
	assign cur_pr   = pr_q[p_idx];
	assign out_free = !rsp_valid_q || !rsp_stall;

	always_comb begin
		stat.act        = act_q;
		stat.full       = (cnt_q == CW'(N));
		stat.p_end      = (p_q >= cnt_q);
		stat.cur_lt     = (cur_dl < key_q);
		stat.cur_le_now = (cur_dl <= now_q);
		stat.cur_fired  = fired_q[p_idx];
		stat.cur_match  = !tgt_q[31] && (cur_id == tgt_q[30:0]);
		stat.cur_per_nz = (cur_pr != '0);
		stat.tgt_ok     = (tgt_q != -32'sd1) && (tgt_q != 32'sd0);
		stat.out_free   = out_free;
		stat.pend_v     = pend_v_q;
		stat.nres_max   = (nres_q == stq_pkg::RES_W'(stq_pkg::MAX_RESULTS));
	end

	always_comb begin
		case (cmd.rkind)
			stq_pkg::KIND_ADDED:   dir_id = ins_id_q;
			stq_pkg::KIND_REMOVED: dir_id = tgt_q[30:0];
			default:               dir_id = '0;
		endcase
		dir_dl = ((cmd.rkind == stq_pkg::KIND_NEXT) && (cnt_q != '0)) ? dl_q[0] : '0;
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			act_q    <= stq_pkg::action_t'(action);
			now_q    <= now_time;
			delay_q  <= start_delay;
			per_in_q <= period;
			rep_q    <= repeating;
			tgt_q    <= target_id;
		end
		if (cmd.add_prep) begin
			key_q     <= stq_pkg::sat_add(now_q, delay_q);
			ins_id_q  <= next_id_q;
			ins_per_q <= rep_q ? per_in_q : '0;
		end else if (cmd.trg_take) begin
			key_q     <= stq_pkg::sat_add(now_q, cur_pr);
			ins_id_q  <= cur_id;
			ins_per_q <= cur_pr;
		end
		if (cmd.ins_at_p) begin
			for (int k = 1; k < N; k++) begin
				if (CW'(k) > p_q) begin
					id_q[k] <= id_q[k-1];
					dl_q[k] <= dl_q[k-1];
					pr_q[k] <= pr_q[k-1];
				end
			end
			id_q[p_idx] <= ins_id_q;
			dl_q[p_idx] <= key_q;
			pr_q[p_idx] <= ins_per_q;
		end else if (cmd.rm_at_p) begin
			for (int k = 0; k < N - 1; k++) begin
				if (CW'(k) >= p_q) begin
					id_q[k] <= id_q[k+1];
					dl_q[k] <= dl_q[k+1];
					pr_q[k] <= pr_q[k+1];
				end
			end
		end
		if (cmd.emit_fire) begin
			pend_id_q   <= ins_id_q;
			pend_live_q <= cnt_q;
		end
		if (cmd.out_direct) begin
			kind_q <= cmd.rkind;
			tid_q  <= dir_id;
			dlo_q  <= dir_dl;
			live_q <= cnt_q;
			last_q <= 1'b1;
		end else if (cmd.out_final) begin
			kind_q <= pend_v_q ? stq_pkg::KIND_FIRED : stq_pkg::KIND_NONE_FIRED;
			tid_q  <= pend_v_q ? pend_id_q : '0;
			dlo_q  <= '0;
			live_q <= pend_v_q ? pend_live_q : cnt_q;
			last_q <= 1'b1;
		end else if (cmd.emit_fire && pend_v_q) begin
			kind_q <= stq_pkg::KIND_FIRED;
			tid_q  <= pend_id_q;
			dlo_q  <= '0;
			live_q <= pend_live_q;
			last_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			next_id_q   <= stq_pkg::ID_FIRST;
			p_q         <= '0;
			fired_q     <= '0;
			ins_fired_q <= 1'b0;
			nres_q      <= '0;
			pend_v_q    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.start || cmd.p_clr) begin
				p_q <= '0;
			end else if (cmd.p_inc) begin
				p_q <= p_q + 1'b1;
			end
			if (cmd.start) begin
				fired_q  <= '0;
				nres_q   <= '0;
				pend_v_q <= 1'b0;
			end
			if (cmd.add_prep) begin
				ins_fired_q <= 1'b0;
				next_id_q   <= (next_id_q == stq_pkg::ID_MAX) ? stq_pkg::ID_FIRST :
				               next_id_q + 1'b1;
			end else if (cmd.trg_take) begin
				ins_fired_q <= 1'b1;
			end
			if (cmd.ins_at_p) begin
				for (int k = 1; k < N; k++) begin
					if (CW'(k) > p_q) begin
						fired_q[k] <= fired_q[k-1];
					end
				end
				fired_q[p_idx] <= ins_fired_q;
				cnt_q <= cnt_q + 1'b1;
			end else if (cmd.rm_at_p) begin
				for (int k = 0; k < N - 1; k++) begin
					if (CW'(k) >= p_q) begin
						fired_q[k] <= fired_q[k+1];
					end
				end
				cnt_q <= cnt_q - 1'b1;
			end
			if (cmd.emit_fire) begin
				pend_v_q <= 1'b1;
				nres_q   <= nres_q + 1'b1;
			end else if (cmd.out_final) begin
				pend_v_q <= 1'b0;
			end
			if (cmd.out_direct || cmd.out_final || (cmd.emit_fire && pend_v_q)) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign kind        = kind_q;
	assign timer_id    = tid_q;
	assign deadline    = dlo_q;
	assign live_timers = 7'(live_q);
	assign last        = last_q;

endmodule

FILE: rtl/core/sorted_timer_queue.sv
// Timer pool of sixteen entries kept sorted by deadline. One request is taken at a
// time; req_stall stays high until the request's last result beat is in the
// output register. The controller walks the sorted list one entry per step: an
// add, a remove and a trigger scan the list, a query reads the head entry, and
// every request also waits while rsp_stall holds a result beat.
module sorted_timer_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [1:0]         action,
	input  logic [30:0]        now_time,
	input  logic [30:0]        start_delay,
	input  logic [30:0]        period,
	input  logic               repeating,
	input  logic signed [31:0] target_id,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic [2:0]         kind,
	output logic [30:0]        timer_id,
	output logic [30:0]        deadline,
	output logic [6:0]         live_timers,
	output logic               last
);

	stq_pkg::ctl_cmd_t cmd;
	stq_pkg::dp_stat_t stat;

	stq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	stq_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.action      (action),
		.now_time    (now_time),
		.start_delay (start_delay),
		.period      (period),
		.repeating   (repeating),
		.target_id   (target_id),
		.rsp_stall   (rsp_stall),
		.rsp_valid   (rsp_valid),
		.kind        (kind),
		.timer_id    (timer_id),
		.deadline    (deadline),
		.live_timers (live_timers),
		.last        (last),
		.cmd         (cmd),
		.stat        (stat)
	);

endmodule

FILE: rtl/core/stq_checker.sv
module stq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        rsp_valid,
	input logic        rsp_stall,
	input logic [2:0]  kind,
	input logic [30:0] timer_id,
	input logic [6:0]  live_timers,
	input logic        last
);

	a_single_beat: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (kind == stq_pkg::KIND_ADDED || kind == stq_pkg::KIND_FULL ||
		kind == stq_pkg::KIND_REMOVED || kind == stq_pkg::KIND_NOT_FOUND ||
		kind == stq_pkg::KIND_NONE_FIRED || kind == stq_pkg::KIND_NEXT) |-> last)
		else $error("single-beat result without last");

	a_no_id: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (kind == stq_pkg::KIND_FULL || kind == stq_pkg::KIND_NOT_FOUND ||
		kind == stq_pkg::KIND_NONE_FIRED || kind == stq_pkg::KIND_NEXT) |-> timer_id == '0)
		else $error("id on a result that carries none");

	a_live_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> live_timers <= 7'(stq_pkg::NUM_TIMERS))
		else $error("live timer count out of range");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && kind == stq_pkg::KIND_FULL |-> live_timers == 7'(stq_pkg::NUM_TIMERS))
		else $error("pool full reported below capacity");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(kind) && $stable(timer_id))
		else $error("stalled result beat changed");

endmodule

bind sorted_timer_queue stq_checker u_stq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.rsp_valid   (rsp_valid),
	.rsp_stall   (rsp_stall),
	.kind        (kind),
	.timer_id    (timer_id),
	.live_timers (live_timers),
	.last        (last)
);
